>>> rtl/supply_voltage_wake_qualifier_defines.svh
// Assertion macros for the supply voltage wake qualifier.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SUPPLY_VOLTAGE_WAKE_QUALIFIER_DEFINES_SVH
`define SUPPLY_VOLTAGE_WAKE_QUALIFIER_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define SVWQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svwq: same-cycle check failed");

// Next-cycle implication under an active-low reset.
`define SVWQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svwq: next-cycle check failed");

`endif

>>> rtl/svwq_pkg.sv
// Shared types and constants of the supply voltage wake qualifier.
// No dependencies; every other RTL file but the defines header uses this package.
package svwq_pkg;

    localparam int RAW_W      = 12;
    localparam int MV_W       = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int QCNT_W     = 2;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QFILL_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_THR   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HYST  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 4'd3;

    localparam logic [RAW_W:0]      SETTLE_LIMIT = 13'd10;
    localparam logic [QCNT_W-1:0]   QUALIFY_MAX  = 2'd3;
    localparam logic [MV_W-1:0]     MV_MAX       = 16'hFFFF;

    // pin_mv = raw * 3300 / 4095, divide by 4095 as multiply by ceil(2^36/4095)
    localparam logic [11:0] PIN_SCALE  = 12'd3300;
    localparam logic [24:0] PIN_RECIP  = 25'd16781314;
    localparam int          PIN_SHIFT  = 36;
    // supply_mv = pin_mv * 115 / 91, divide by 91 as multiply by ceil(2^26/91)
    localparam logic [6:0]  SUP_SCALE  = 7'd115;
    localparam logic [19:0] SUP_RECIP  = 20'd737461;
    localparam int          SUP_SHIFT  = 26;

    typedef struct packed {
        logic             push;
        logic [RAW_W-1:0] sample;
    } q_push_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [RAW_W-1:0] head;
    } q_status_t;

endpackage

>>> rtl/svwq_ifs.sv
// Handshake channels of the supply voltage wake qualifier: samples, results, config.
// Depends on svwq_pkg for field widths.
interface svwq_sample_if;
    logic                         valid;
    logic                         ready;
    logic [svwq_pkg::RAW_W-1:0]   raw_sample;
    logic                         round_start;
    modport source (output valid, output raw_sample, output round_start, input ready);
    modport sink   (input valid, input raw_sample, input round_start, output ready);
endinterface

interface svwq_result_if;
    logic                         valid;
    logic                         ready;
    logic [svwq_pkg::MV_W-1:0]    voltage_mv;
    logic                         in_holdoff;
    logic                         wake;
    modport source (output valid, output voltage_mv, output in_holdoff, output wake,
                    input ready);
    modport sink   (input valid, input voltage_mv, input in_holdoff, input wake,
                    output ready);
endinterface

interface svwq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [svwq_pkg::CFG_IDX_W-1:0]  index;
    logic [svwq_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/svwq_front.sv
// Front end: accepts sample beats, tracks the settling pair, queues settled readings.
// Depends on svwq_pkg and svwq_ifs.
`include "supply_voltage_wake_qualifier_defines.svh"
module svwq_front (
    input  logic                clk,
    input  logic                rst_n,
    svwq_sample_if.sink         samples,
    input  svwq_pkg::q_status_t q_status,
    output svwq_pkg::q_push_t   q_push
);
    import svwq_pkg::*;

    logic [RAW_W-1:0] prev_sample_reg;
    logic [RAW_W-1:0] prev_sample_next;
    logic             prev_valid_reg;
    logic             prev_valid_next;
    logic             accept;
    logic             first;
    logic [RAW_W:0]   diff;
    logic             settled;

    assign samples.ready = !q_status.full;
    assign accept        = samples.valid && samples.ready;
    assign first         = samples.round_start || !prev_valid_reg;
    assign diff          = (samples.raw_sample >= prev_sample_reg)
                         ? {1'b0, samples.raw_sample} - {1'b0, prev_sample_reg}
                         : {1'b0, prev_sample_reg} - {1'b0, samples.raw_sample};
    assign settled       = !first && (diff < SETTLE_LIMIT);

    always_comb
    begin
        prev_sample_next = prev_sample_reg;
        prev_valid_next  = prev_valid_reg;
        q_push.push      = 1'b0;
        q_push.sample    = samples.raw_sample;
        if (accept)
        begin
            if (settled)
            begin
                prev_valid_next = 1'b0;
                q_push.push     = 1'b1;
            end
            else
            begin
                prev_sample_next = samples.raw_sample;
                prev_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_sample_reg <= prev_sample_next;
    end

    `SVWQ_ASSERT_IMP(a_front_no_push_full, clk, rst_n, q_push.push, !q_status.full)
    `SVWQ_ASSERT_NXT(a_front_push_ends_pair, clk, rst_n, q_push.push, !prev_valid_reg)
endmodule

>>> rtl/svwq_fifo.sv
// Two-entry queue of settled raw samples between front and back.
// Depends on svwq_pkg.
module svwq_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  svwq_pkg::q_push_t   q_push,
    input  logic                pop,
    output svwq_pkg::q_status_t q_status
);
    import svwq_pkg::*;

    logic [RAW_W-1:0]   mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;
    logic [QFILL_W-1:0] fill_next;

    assign q_status.full  = (fill_reg == QFILL_W'(QDEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign q_status.head  = mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (q_push.push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !q_push.push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (q_push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            mem[wr_ptr_reg] <= q_push.sample;
        end
    end
endmodule

>>> rtl/svwq_back.sv
// Back end: config registers, multi-cycle millivolt conversion, hold-off and wake logic,
// result register. Depends on svwq_pkg and svwq_ifs.
`include "supply_voltage_wake_qualifier_defines.svh"
module svwq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  svwq_pkg::q_status_t q_status,
    output logic                pop,
    svwq_cfg_if.sink            cfg,
    svwq_result_if.source       results
);
    import svwq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_DIV2 = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic [MV_W-1:0]   thr_reg;
    logic [MV_W-1:0]   hyst_reg;
    logic [MV_W-1:0]   offset_reg;
    logic [MV_W-1:0]   limit_reg;
    logic [MV_W:0]     limit_sum;

    logic [23:0]       x_reg;
    logic [12:0]       pin_reg;
    logic [18:0]       y_reg;
    logic [12:0]       sup_reg;
    logic [48:0]       prod1;
    logic [19:0]       prod2;
    logic [38:0]       prod3;

    logic signed [17:0] sum_mv;
    logic [MV_W-1:0]   mv;
    logic              hit;

    logic [MV_W-1:0]   holdoff_reg;
    logic [MV_W-1:0]   holdoff_next;
    logic [QCNT_W-1:0] qual_reg;
    logic [QCNT_W-1:0] qual_next;
    logic              wake_reg;
    logic              wake_next;
    logic              held;

    logic              out_valid_reg;
    logic [MV_W-1:0]   out_mv_reg;
    logic              out_held_reg;
    logic              out_wake_reg;

    logic              cfg_wr;
    logic              fire;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    assign results.valid      = out_valid_reg;
    assign results.voltage_mv = out_mv_reg;
    assign results.in_holdoff = out_held_reg;
    assign results.wake       = out_wake_reg;

    assign pop  = (state_reg == ST_IDLE) && !q_status.empty;
    assign fire = (state_reg == ST_OUT) && (!out_valid_reg || results.ready);

    assign limit_sum = {1'b0, thr_reg} + {1'b0, hyst_reg};
    assign prod1 = {25'd0, x_reg} * {24'd0, PIN_RECIP};
    assign prod2 = {7'd0, pin_reg} * {13'd0, SUP_SCALE};
    assign prod3 = {20'd0, y_reg} * {19'd0, SUP_RECIP};

    assign sum_mv = $signed({5'd0, sup_reg}) + $signed({{2{offset_reg[MV_W-1]}}, offset_reg});
    assign mv     = sum_mv[17] ? '0 : sum_mv[MV_W-1:0];
    assign hit    = (mv >= limit_reg);
    assign held   = (holdoff_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIV2;
            ST_DIV2: state_next = ST_OUT;
            ST_OUT:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        holdoff_next = holdoff_reg;
        qual_next    = qual_reg;
        wake_next    = wake_reg;
        if (fire)
        begin
            if (held)
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
            else
            begin
                if (hit)
                begin
                    qual_next = (qual_reg == QUALIFY_MAX) ? qual_reg : qual_reg + 1'b1;
                end
                else
                begin
                    qual_next = '0;
                end
                if (qual_next == QUALIFY_MAX)
                begin
                    wake_next = 1'b1;
                end
            end
        end
        if (cfg_wr && (cfg.index == CFG_HOLDOFF))
        begin
            holdoff_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= '0;
            hyst_reg      <= '0;
            offset_reg    <= '0;
            limit_reg     <= '0;
            holdoff_reg   <= '0;
            qual_reg      <= '0;
            wake_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            holdoff_reg <= holdoff_next;
            qual_reg    <= qual_next;
            wake_reg    <= wake_next;
            limit_reg   <= limit_sum[MV_W] ? MV_MAX : limit_sum[MV_W-1:0];
            if (cfg_wr)
            begin
                case (cfg.index)
                    CFG_WAKE_THR:   thr_reg    <= cfg.data;
                    CFG_WAKE_HYST:  hyst_reg   <= cfg.data;
                    CFG_CAL_OFFSET: offset_reg <= cfg.data;
                    default:        ;
                endcase
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg <= 24'(q_status.head) * 24'(PIN_SCALE);
        end
        pin_reg <= prod1[48:PIN_SHIFT];
        y_reg   <= prod2[18:0];
        sup_reg <= prod3[38:SUP_SHIFT];
        if (fire)
        begin
            out_mv_reg   <= mv;
            out_held_reg <= held;
            out_wake_reg <= wake_next;
        end
    end

    `SVWQ_ASSERT_NXT(a_back_wake_sticky, clk, rst_n, wake_reg, wake_reg)
    `SVWQ_ASSERT_NXT(a_back_qual_wakes, clk, rst_n, fire && (qual_next == QUALIFY_MAX), wake_reg)
    `SVWQ_ASSERT_NXT(a_back_holdoff_dec, clk, rst_n, fire && held && !cfg_wr, holdoff_reg == $past(holdoff_reg) - 1'b1)
    `SVWQ_ASSERT_IMP(a_back_held_keeps_qual, clk, rst_n, fire && held, qual_next == qual_reg)
endmodule

>>> rtl/supply_voltage_wake_qualifier.sv
// A settled reading goes via the two-entry queue to the idle back end: x_reg, pin_reg,
// y_reg, sup_reg, result register; results.ready can stall it, and no new reading is
// popped meanwhile. Sample beats are taken every cycle while the queue has room.
// Configuration writes are always accepted (ready is always high).
// Reset (rst_n low, asynchronous) clears the pair tracker, queue, counters, wake flag
// and config registers; the block is ready as soon as reset is released.
module supply_voltage_wake_qualifier (
    input  logic           clk,
    input  logic           rst_n,
    svwq_sample_if.sink    samples,
    svwq_cfg_if.sink       cfg,
    svwq_result_if.source  results
);
    import svwq_pkg::*;

    q_push_t   q_push;
    q_status_t q_status;
    logic      pop;

    svwq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .q_push   (q_push)
    );

    svwq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status)
    );

    svwq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop      (pop),
        .cfg      (cfg),
        .results  (results)
    );
endmodule
